[design/pl2d_pkg.sv]
// Package for the two-dimensional pooling block: sizes, register map, mode codes
// and the divider step used by the averaging path.
// No dependencies; used by pool2d_forward.
package pl2d_pkg;

  // Plane and window limits.
  localparam int unsigned MaxPlaneW  = 64;
  localparam int unsigned MaxPlaneH  = 64;
  localparam int unsigned MaxWindow  = 16;
  localparam int unsigned StoreDepth = MaxPlaneW * MaxPlaneH;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  // Field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned WinW    = 5;
  localparam int unsigned DimW    = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned OrgW    = 11;
  localparam int unsigned AreaW   = 9;
  localparam int unsigned SumW    = 25;
  localparam int unsigned MagW    = 24;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] RegPoolMode  = 3'd0;
  localparam logic [2:0] RegWinWidth  = 3'd1;
  localparam logic [2:0] RegWinHeight = 3'd2;
  localparam logic [2:0] RegStrideX   = 3'd3;
  localparam logic [2:0] RegStrideY   = 3'd4;
  localparam logic [2:0] RegInWidth   = 3'd5;
  localparam logic [2:0] RegInHeight  = 3'd6;

  // Pooling mode codes; the unused code behaves as max.
  localparam logic [1:0] ModeMax     = 2'd0;
  localparam logic [1:0] ModeAvgFull = 2'd1;
  localparam logic [1:0] ModeAvgClip = 2'd2;

  // Item function codes.
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncPool = 1'b1;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]      pool_mode;
    logic [WinW-1:0] window_width;
    logic [WinW-1:0] window_height;
    logic [WinW-1:0] stride_x;
    logic [WinW-1:0] stride_y;
    logic [DimW-1:0] in_width;
    logic [DimW-1:0] in_height;
  } cfg_t;

  // Window size: zero acts as one, anything above the limit saturates.
  function automatic logic [WinW-1:0] clamp_window(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    if (w == '0) begin
      r = WinW'(1);
    end else if (w > WinW'(MaxWindow)) begin
      r = WinW'(MaxWindow);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // Plane size saturates at the store geometry.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d,
                                                input logic [DimW-1:0] lim);
    return (d > lim) ? lim : d;
  endfunction

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [AreaW:0] div_step(input logic [AreaW-1:0] rem,
                                              input logic             din,
                                              input logic [AreaW-1:0] dvs);
    logic [AreaW:0]   trial;
    logic [AreaW:0]   diff;
    logic [AreaW:0]   r;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      r = {1'b1, diff[AreaW-1:0]};
    end else begin
      r = {1'b0, trial[AreaW-1:0]};
    end
    return r;
  endfunction

endpackage

[design/pool2d_forward.sv]
// Two-dimensional max / average pooling over one feature plane held in a local store.
// Holds the plane store, the scan sequencer, a shared two-bit-per-cycle divider and
// the register file. Depends on pl2d_pkg.
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// A load item (func_i low) writes sample_i into the plane store at the running write
// pointer; first_i restarts the pointer at zero. It gives no result and busy stays
// low, so loads may follow back to back.
// A pool item (func_i high) names an output position (out_x_i, out_y_i). Busy rises for
// the whole computation, and the result appears on the result ports for exactly one
// cycle with result_valid_o high; busy is already low in that cycle.
// The scan reads one sample per cycle through the single read port of the store; the
// divider retires two quotient bits a cycle over a 24-bit magnitude.
// The user must write the registers over the APB port only while the block is idle;
// the block itself does not enforce it.
// Reset clears the sequencer, the write pointer and the registers to their defaults;
// the store content is undefined until written. The receiver cannot stall results.
module pool2d_forward (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic signed [pl2d_pkg::SampleW-1:0] sample_i,
  input  logic                                first_i,
  input  logic        [pl2d_pkg::PosW-1:0]    out_x_i,
  input  logic        [pl2d_pkg::PosW-1:0]    out_y_i,
  // Result channel
  output logic                                result_valid_o,
  output logic signed [pl2d_pkg::SampleW-1:0] pool_value_o,
  output logic        [pl2d_pkg::AddrW-1:0]   max_position_o,
  output logic                                position_valid_o,
  output logic                                empty_window_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [4:0]                   paddr,
  input  logic        [31:0]                  pwdata,
  output logic        [31:0]                  prdata,
  output logic                                pready
);

  localparam int unsigned AddrW   = pl2d_pkg::AddrW;
  localparam int unsigned SampleW = pl2d_pkg::SampleW;
  localparam int unsigned WinW    = pl2d_pkg::WinW;
  localparam int unsigned DimW    = pl2d_pkg::DimW;
  localparam int unsigned PosW    = pl2d_pkg::PosW;
  localparam int unsigned OrgW    = pl2d_pkg::OrgW;
  localparam int unsigned AreaW   = pl2d_pkg::AreaW;
  localparam int unsigned SumW    = pl2d_pkg::SumW;
  localparam int unsigned MagW    = pl2d_pkg::MagW;
  localparam int unsigned DivCycles = MagW / 2;
  localparam int unsigned DivCntW   = $clog2(DivCycles);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_CLIP,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_DIV
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  pl2d_pkg::cfg_t cfg_q;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Register writes land on the access beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_mode     <= pl2d_pkg::ModeMax;
      cfg_q.window_width  <= WinW'(2);
      cfg_q.window_height <= WinW'(2);
      cfg_q.stride_x      <= WinW'(2);
      cfg_q.stride_y      <= WinW'(2);
      cfg_q.in_width      <= DimW'(pl2d_pkg::MaxPlaneW);
      cfg_q.in_height     <= DimW'(pl2d_pkg::MaxPlaneH);
    end else if (cfg_we) begin
      case (paddr[4:2])
        pl2d_pkg::RegPoolMode:  cfg_q.pool_mode     <= pwdata[1:0];
        pl2d_pkg::RegWinWidth:  cfg_q.window_width  <= pwdata[WinW-1:0];
        pl2d_pkg::RegWinHeight: cfg_q.window_height <= pwdata[WinW-1:0];
        pl2d_pkg::RegStrideX:   cfg_q.stride_x      <= pwdata[WinW-1:0];
        pl2d_pkg::RegStrideY:   cfg_q.stride_y      <= pwdata[WinW-1:0];
        pl2d_pkg::RegInWidth:   cfg_q.in_width      <= pwdata[DimW-1:0];
        pl2d_pkg::RegInHeight:  cfg_q.in_height     <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      pl2d_pkg::RegPoolMode:  prdata = 32'(cfg_q.pool_mode);
      pl2d_pkg::RegWinWidth:  prdata = 32'(cfg_q.window_width);
      pl2d_pkg::RegWinHeight: prdata = 32'(cfg_q.window_height);
      pl2d_pkg::RegStrideX:   prdata = 32'(cfg_q.stride_x);
      pl2d_pkg::RegStrideY:   prdata = 32'(cfg_q.stride_y);
      pl2d_pkg::RegInWidth:   prdata = 32'(cfg_q.in_width);
      pl2d_pkg::RegInHeight:  prdata = 32'(cfg_q.in_height);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Plane store and write pointer
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] store_mem [pl2d_pkg::StoreDepth];
  logic [SampleW-1:0] rdata_q;
  logic [AddrW-1:0]   wp_q;
  logic [AddrW-1:0]   waddr;
  logic               accept;
  logic               mem_we;
  logic [AddrW-1:0]   addr_q;
  state_e             state_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (func_i == pl2d_pkg::FuncLoad);
  assign waddr  = first_i ? '0 : wp_q;

  // One write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[waddr] <= sample_i;
    end
    rdata_q <= store_mem[addr_q];
  end

  // The write pointer wraps naturally at the store depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (mem_we) begin
      wp_q <= waddr + AddrW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, accumulators, divider and result registers
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]        ox_q, oy_q;
  logic [1:0]             mode_q;
  logic [WinW-1:0]        ww_q, wh_q;
  logic [DimW-1:0]        pw_q, ph_q;
  logic [OrgW-1:0]        x0_q, y0_q;
  logic [PosW-1:0]        x_q, y_q, ystart_q;
  logic [DimW-1:0]        x_end_q, y_end_q;
  logic [AddrW-1:0]       col_q;
  logic [AreaW-1:0]       area_q;
  logic                   rd_vld_q;
  logic [AddrW-1:0]       idx_p_q;
  logic signed [SumW-1:0] sum_q;
  logic [AreaW-1:0]       count_q;
  logic signed [SampleW-1:0] best_q;
  logic [AddrW-1:0]       best_pos_q;
  logic [MagW-1:0]        dvd_q;
  logic [MagW-1:0]        quo_q;
  logic [AreaW-1:0]       rem_q;
  logic [AreaW-1:0]       dvs_q;
  logic                   neg_q;
  logic [DivCntW-1:0]     div_cnt_q;
  logic                   res_valid_q;
  logic signed [SampleW-1:0] res_value_q;
  logic [AddrW-1:0]       res_pos_q;
  logic                   res_pvalid_q;
  logic                   res_empty_q;

  // Clipping arithmetic for the window origin.
  logic [OrgW:0]          x_lim, y_lim;
  logic [DimW-1:0]        x_end, y_end;
  logic                   win_empty;
  logic [AddrW-1:0]       base_addr;
  logic                   is_max;

  assign x_lim     = {1'b0, x0_q} + (OrgW+1)'(ww_q);
  assign y_lim     = {1'b0, y0_q} + (OrgW+1)'(wh_q);
  assign x_end     = (x_lim > (OrgW+1)'(pw_q)) ? pw_q : x_lim[DimW-1:0];
  assign y_end     = (y_lim > (OrgW+1)'(ph_q)) ? ph_q : y_lim[DimW-1:0];
  assign win_empty = (x0_q >= OrgW'(pw_q)) || (y0_q >= OrgW'(ph_q));
  assign base_addr = AddrW'(x0_q[PosW-1:0]) + AddrW'(y0_q[PosW-1:0]) * AddrW'(pw_q);
  assign is_max    = (mode_q != pl2d_pkg::ModeAvgFull) && (mode_q != pl2d_pkg::ModeAvgClip);

  // Two restoring steps of the shared divider per cycle.
  logic [AreaW:0] step_a, step_b;
  logic [SumW-1:0] sum_abs;

  assign step_a  = pl2d_pkg::div_step(rem_q, dvd_q[MagW-1], dvs_q);
  assign step_b  = pl2d_pkg::div_step(step_a[AreaW-1:0], dvd_q[MagW-2], dvs_q);
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  // Sample taken from the store on the previous scan beat.
  logic signed [SampleW-1:0] rd_sample;
  assign rd_sample = $signed(rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ox_q         <= '0;
      oy_q         <= '0;
      mode_q       <= pl2d_pkg::ModeMax;
      ww_q         <= '0;
      wh_q         <= '0;
      pw_q         <= '0;
      ph_q         <= '0;
      x0_q         <= '0;
      y0_q         <= '0;
      x_q          <= '0;
      y_q          <= '0;
      ystart_q     <= '0;
      x_end_q      <= '0;
      y_end_q      <= '0;
      col_q        <= '0;
      addr_q       <= '0;
      area_q       <= '0;
      rd_vld_q     <= 1'b0;
      idx_p_q      <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      best_q       <= '0;
      best_pos_q   <= '0;
      dvd_q        <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      dvs_q        <= '0;
      neg_q        <= 1'b0;
      div_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
      res_value_q  <= '0;
      res_pos_q    <= '0;
      res_pvalid_q <= 1'b0;
      res_empty_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;

      // Fold in the sample read on the previous beat; the first one always wins.
      if (rd_vld_q) begin
        sum_q   <= sum_q + SumW'(rd_sample);
        count_q <= count_q + AreaW'(1);
        if ((count_q == '0) || (rd_sample > best_q)) begin
          best_q     <= rd_sample;
          best_pos_q <= idx_p_q;
        end
      end

      case (state_q)
        // Take a pool item and latch its position, the mode and the window and plane sizes.
        ST_IDLE: begin
          if (accept && (func_i == pl2d_pkg::FuncPool)) begin
            ox_q    <= out_x_i;
            oy_q    <= out_y_i;
            mode_q  <= cfg_q.pool_mode;
            ww_q    <= pl2d_pkg::clamp_window(cfg_q.window_width);
            wh_q    <= pl2d_pkg::clamp_window(cfg_q.window_height);
            pw_q    <= pl2d_pkg::clamp_dim(cfg_q.in_width, DimW'(pl2d_pkg::MaxPlaneW));
            ph_q    <= pl2d_pkg::clamp_dim(cfg_q.in_height, DimW'(pl2d_pkg::MaxPlaneH));
            sum_q   <= '0;
            count_q <= '0;
            best_q  <= {1'b1, {(SampleW-1){1'b0}}};
            best_pos_q <= '0;
            state_q <= ST_ORIGIN;
          end
        end

        // Window origin from position and stride.
        ST_ORIGIN: begin
          x0_q    <= OrgW'(ox_q) * OrgW'(cfg_q.stride_x);
          y0_q    <= OrgW'(oy_q) * OrgW'(cfg_q.stride_y);
          area_q  <= AreaW'(ww_q) * AreaW'(wh_q);
          state_q <= ST_CLIP;
        end

        // Clip at the plane edge and set up the column-major walk.
        ST_CLIP: begin
          x_q      <= x0_q[PosW-1:0];
          y_q      <= y0_q[PosW-1:0];
          ystart_q <= y0_q[PosW-1:0];
          x_end_q  <= x_end;
          y_end_q  <= y_end;
          col_q    <= base_addr;
          addr_q   <= base_addr;
          state_q  <= win_empty ? ST_EVAL : ST_SCAN;
        end

        // One store read per cycle, rows inside columns.
        ST_SCAN: begin
          rd_vld_q <= 1'b1;
          idx_p_q  <= addr_q;
          if (({1'b0, y_q} + DimW'(1)) < y_end_q) begin
            y_q    <= y_q + PosW'(1);
            addr_q <= addr_q + AddrW'(pw_q);
          end else if (({1'b0, x_q} + DimW'(1)) < x_end_q) begin
            x_q    <= x_q + PosW'(1);
            y_q    <= ystart_q;
            col_q  <= col_q + AddrW'(1);
            addr_q <= col_q + AddrW'(1);
          end else begin
            state_q <= ST_DRAIN;
          end
        end

        // Last read data is folded in on this beat.
        ST_DRAIN: begin
          state_q <= ST_EVAL;
        end

        // Finish max mode or an empty average, else start the divider.
        ST_EVAL: begin
          if (is_max) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= best_q;
            res_pos_q    <= (count_q != '0) ? best_pos_q : '0;
            res_pvalid_q <= (count_q != '0);
            res_empty_q  <= (count_q == '0);
            state_q      <= ST_IDLE;
          end else if (count_q == '0) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= '0;
            res_pos_q    <= '0;
            res_pvalid_q <= 1'b0;
            res_empty_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end else begin
            dvd_q     <= sum_abs[MagW-1:0];
            neg_q     <= sum_q[SumW-1];
            dvs_q     <= (mode_q == pl2d_pkg::ModeAvgFull) ? area_q : count_q;
            rem_q     <= '0;
            quo_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end

        // Restoring division of the magnitude, then the sign is put back.
        ST_DIV: begin
          rem_q     <= step_b[AreaW-1:0];
          quo_q     <= {quo_q[MagW-3:0], step_a[AreaW], step_b[AreaW]};
          dvd_q     <= {dvd_q[MagW-3:0], 2'b00};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(DivCycles - 1)) begin
            res_valid_q  <= 1'b1;
            res_value_q  <= neg_q
                ? SampleW'(-{quo_q[MagW-3:0], step_a[AreaW], step_b[AreaW]})
                : SampleW'({quo_q[MagW-3:0], step_a[AreaW], step_b[AreaW]});
            res_pos_q    <= '0;
            res_pvalid_q <= 1'b0;
            res_empty_q  <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o   = res_valid_q;
  assign pool_value_o     = res_value_q;
  assign max_position_o   = res_pos_q;
  assign position_valid_o = res_pvalid_q;
  assign empty_window_o   = res_empty_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result is a single-cycle strobe and never repeats on the next beat.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result never coincides with a busy sequencer.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result delivered while busy");

  // An empty window never reports a recorded maximum position.
  a_empty_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && empty_window_o) |-> !position_valid_o)
    else $error("empty window with a valid position");

  // The scan never runs past the clipped window in either direction.
  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (({1'b0, y_q} < y_end_q) && ({1'b0, x_q} < x_end_q)))
    else $error("scan outside the clipped window");

  // The sample count never exceeds the largest window area.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= AreaW'(pl2d_pkg::MaxWindow * pl2d_pkg::MaxWindow))
    else $error("sample count beyond the largest window");

endmodule
